// ===== src/mtes_pkg.sv =====
// shared constants and types for the multichannel threshold event stamper
`default_nettype none

package mtes_pkg;

    // field widths fixed by the stream format
    localparam int SAMPLE_W      = 16;
    localparam int TIME_W        = 24;
    localparam int CHAN_W        = 3;
    localparam int WORD_W        = 32;
    localparam int COUNT_CFG_W   = 4;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 64;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // parameter defaults
    localparam int DEFAULT_MAX_CHANNELS = 8;
    localparam int DEFAULT_SAMPLE_BITS  = 16;

    // register reset values
    localparam logic [SAMPLE_W-1:0]    THRESHOLD_RESET = 16'd40960;
    localparam logic [COUNT_CFG_W-1:0] CHAN_COUNT_RESET = 4'd8;

    // event word layout: bits 24..27 stay zero
    localparam int LEVEL_SHIFT   = 28;
    localparam int CHANNEL_SHIFT = 29;

    // register select, taken from paddr[2]
    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_CHAN_COUNT = 1'b1
    } reg_sel_t;

    // one event item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CHAN_W-1:0] channel;
        logic              level;
        logic [TIME_W-1:0] stamp;
    } event_t;

endpackage

`default_nettype wire

// ===== src/multichannel_threshold_event_stamper.sv =====
// top level: threshold compare per channel, change detection and event stamping
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid / tready        | sample_code, record_enable
//  m_axis    | out       | tvalid / tready        | event time, level, channel, word
//  apb       | in        | psel / penable / pready | threshold_code, channel_count
//
// one item per cycle while the skid register is empty; the compare, level update
// and counter update all happen in the cycle an item is accepted. its event goes
// to an output register, or to a one-entry skid register while m_axis stalls; they
// part the sides: s_axis_tready hangs only on the skid register, not on m_axis_tready.
// synchronous active-low reset clears the channel index, the sample counter and the
// per-channel known flags, and loads both configuration registers with reset values.
`default_nettype none

module multichannel_threshold_event_stamper #(
    parameter int MAX_CHANNELS = mtes_pkg::DEFAULT_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mtes_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // [15:0] sample_code, [16] record_enable, [23:17] zero
    input  wire logic [mtes_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // result stream
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [23:0] event_time, [24] event_level, [27:25] event_channel,
    // [59:28] event_word, [63:60] zero
    output      logic [mtes_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mtes_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mtes_pkg::APB_DATA_W-1:0]     pwdata,
    output      logic [mtes_pkg::APB_DATA_W-1:0]     prdata,
    output      logic                                pready
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [mtes_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        mtes_pkg::SAMPLE_W'((17'd1 << SAMPLE_BITS) - 17'd1);
    localparam logic [mtes_pkg::COUNT_CFG_W-1:0] MAX_COUNT =
        mtes_pkg::COUNT_CFG_W'(MAX_CHANNELS);

    // configuration registers
    logic [mtes_pkg::SAMPLE_W-1:0]    threshold_reg;
    logic [mtes_pkg::COUNT_CFG_W-1:0] chan_count_reg;

    // channel state
    logic [mtes_pkg::CHAN_W-1:0] chan_index_reg, chan_index_next;
    logic [mtes_pkg::TIME_W-1:0] sample_count_reg, sample_count_next;
    logic [MAX_CHANNELS-1:0]     known_reg;
    logic [MAX_CHANNELS-1:0]     level_reg;

    // output register and skid register
    logic              out_valid_reg, out_valid_next;
    mtes_pkg::event_t  out_reg, out_next;
    logic              skid_valid_reg, skid_valid_next;
    mtes_pkg::event_t  skid_reg, skid_next;

    logic                              accept;
    logic [mtes_pkg::SAMPLE_W-1:0]     sample;
    logic                              record;
    logic [IDX_W-1:0]                  idx;
    logic                              level_new;
    logic                              change;
    logic                              produce;
    logic [mtes_pkg::COUNT_CFG_W-1:0]  eff_count;
    logic [mtes_pkg::COUNT_CFG_W-1:0]  index_plus;
    mtes_pkg::event_t                  ev;
    logic                              cfg_write;
    mtes_pkg::reg_sel_t                reg_sel;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_sel   = mtes_pkg::reg_sel_t'(paddr[2]);

    always_comb begin
        case (reg_sel)
            mtes_pkg::REG_THRESHOLD:  prdata = mtes_pkg::APB_DATA_W'(threshold_reg);
            mtes_pkg::REG_CHAN_COUNT: prdata = mtes_pkg::APB_DATA_W'(chan_count_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= mtes_pkg::THRESHOLD_RESET;
            chan_count_reg <= mtes_pkg::CHAN_COUNT_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                mtes_pkg::REG_THRESHOLD:
                    threshold_reg <= pwdata[mtes_pkg::SAMPLE_W-1:0];
                mtes_pkg::REG_CHAN_COUNT:
                    chan_count_reg <= pwdata[mtes_pkg::COUNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // input unpack and level compare
    assign s_axis_tready = ~skid_valid_reg;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign sample        = s_axis_tdata[mtes_pkg::SAMPLE_W-1:0] & SAMPLE_MASK;
    assign record        = s_axis_tdata[mtes_pkg::SAMPLE_W];
    assign idx           = chan_index_reg[IDX_W-1:0];
    assign level_new     = (sample > threshold_reg);
    assign change        = ~known_reg[idx] | (level_reg[idx] != level_new);
    assign produce       = accept & change & record;

    // event fields
    always_comb begin
        ev.stamp   = sample_count_reg;
        ev.level   = level_new;
        ev.channel = chan_index_reg;
        ev.word    = {chan_index_reg, level_new,
                      (mtes_pkg::LEVEL_SHIFT - mtes_pkg::TIME_W)'(0), sample_count_reg};
    end

    // clamp the channel count and step the index
    always_comb begin
        if (chan_count_reg == '0) begin
            eff_count = mtes_pkg::COUNT_CFG_W'(1);
        end else if (chan_count_reg > MAX_COUNT) begin
            eff_count = MAX_COUNT;
        end else begin
            eff_count = chan_count_reg;
        end
        index_plus = mtes_pkg::COUNT_CFG_W'(chan_index_reg) + mtes_pkg::COUNT_CFG_W'(1);
        if (index_plus >= eff_count) begin
            chan_index_next = '0;
        end else begin
            chan_index_next = index_plus[mtes_pkg::CHAN_W-1:0];
        end
        // counter advances after each channel-0 item, wraps naturally
        if (chan_index_reg == '0) begin
            sample_count_next = sample_count_reg + mtes_pkg::TIME_W'(1);
        end else begin
            sample_count_next = sample_count_reg;
        end
    end

    // channel state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_index_reg   <= '0;
            sample_count_reg <= '0;
            known_reg        <= '0;
        end else if (accept) begin
            chan_index_reg   <= chan_index_next;
            sample_count_reg <= sample_count_next;
            known_reg[idx]   <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            level_reg[idx] <= level_new;
        end
    end

    // output and skid steering
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = produce;
                out_next       = ev;
            end
        end else if (produce) begin
            skid_valid_next = 1'b1;
            skid_next       = ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // result pack
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mtes_pkg::M_TDATA_W'(out_reg);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the multichannel threshold event stamper: directed and random streams
`timescale 1ns / 1ps

module tb;

    import mtes_pkg::*;

    localparam int          MAX_CH        = DEFAULT_MAX_CHANNELS;
    localparam logic [1:0]  LEVEL_UNKNOWN = 2'd2;
    localparam int          IDLE_PCT      = 22;
    localparam int          SETTLE_CYCLES = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    multichannel_threshold_event_stamper u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    // mirror of the block: configuration, scan position, channel levels, stamp counter
    logic [SAMPLE_W-1:0]    thr_cfg;
    logic [COUNT_CFG_W-1:0] chan_count_cfg;
    logic [CHAN_W-1:0]      cur_chan;
    logic [1:0]             chan_lvl [MAX_CH];
    logic [TIME_W-1:0]      scan_count;
    event_t                 pending_events [$];

    int unsigned mismatch_count = 0;
    bit          src_gaps = 1'b0;
    bit          snk_gaps = 1'b0;
    int unsigned hold_len = 0;
    int unsigned hold_seq = 0;

    function automatic bit idle_roll(input bit enabled);
        return enabled && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void clear_levels();
        thr_cfg        = THRESHOLD_RESET;
        chan_count_cfg = CHAN_COUNT_RESET;
        cur_chan       = '0;
        scan_count     = '0;
        for (int i = 0; i < MAX_CH; i++) chan_lvl[i] = LEVEL_UNKNOWN;
    endfunction

    // compare, level tracking and event stamping for one accepted sample
    function automatic void stamp_sample(input logic [SAMPLE_W-1:0] code, input logic rec);
        int     eff;
        logic   lvl;
        event_t ev;
        eff = (chan_count_cfg == 0) ? 1 :
              ((int'(chan_count_cfg) > MAX_CH) ? MAX_CH : int'(chan_count_cfg));
        lvl = (code > thr_cfg);
        if (chan_lvl[cur_chan] != {1'b0, lvl}) begin
            chan_lvl[cur_chan] = {1'b0, lvl};
            if (rec) begin
                ev.stamp   = scan_count;
                ev.level   = lvl;
                ev.channel = cur_chan;
                ev.word    = {cur_chan, lvl, 4'b0000, scan_count};
                pending_events.push_back(ev);
            end
        end
        if (cur_chan == 0) scan_count = scan_count + 1'b1;
        if (int'(cur_chan) + 1 >= eff) cur_chan = '0;
        else cur_chan = cur_chan + 1'b1;
    endfunction

    // sample source: enter and leave at a falling edge, valid drops only in random gaps
    task automatic send_sample(input logic [SAMPLE_W-1:0] code, input logic rec);
        while (idle_roll(src_gaps)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W - 1){1'b0}}, rec, code};
        do @(posedge aclk); while (!s_axis_tready);
        stamp_sample(code, rec);
        @(negedge aclk);
    endtask

    // stop offering and let every outstanding event drain
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // register write while idle; unused upper bus bits carry noise
    task automatic cfg_write(input reg_sel_t sel, input logic [SAMPLE_W-1:0] value);
        logic [APB_DATA_W-1:0] bus_word;
        wait_drained();
        bus_word = $urandom();
        if (sel == REG_THRESHOLD) bus_word[SAMPLE_W-1:0] = value;
        else bus_word[COUNT_CFG_W-1:0] = value[COUNT_CFG_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= bus_word;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (sel == REG_THRESHOLD) thr_cfg = bus_word[SAMPLE_W-1:0];
        else chan_count_cfg = bus_word[COUNT_CFG_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register read back against the mirrored value, starting from an idle bus
    task automatic cfg_check(input reg_sel_t sel);
        logic [APB_DATA_W-1:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        if (sel == REG_THRESHOLD) begin
            if (got[SAMPLE_W-1:0] !== thr_cfg) begin
                $error("threshold_code: expected %0d, got %0d", thr_cfg, got[SAMPLE_W-1:0]);
                mismatch_count++;
            end
        end else if (got[COUNT_CFG_W-1:0] !== chan_count_cfg) begin
            $error("channel_count: expected %0d, got %0d",
                   chan_count_cfg, got[COUNT_CFG_W-1:0]);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random code: nearly half close to the threshold so levels flip often
    function automatic logic [SAMPLE_W-1:0] pick_code();
        int unsigned roll;
        int          v;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            v = int'(thr_cfg) + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return v[SAMPLE_W-1:0];
        end
        if (roll < 55) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return $urandom_range(0, 65535);
    endfunction

    // result sink: random stalls plus long hold-offs on request
    initial begin
        int unsigned hold_left;
        int unsigned seen_seq;
        hold_left     = 0;
        seen_seq      = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!aresetn) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !idle_roll(snk_gaps);
            end
        end
    end

    // event checker: each accepted item against the oldest expectation
    always @(posedge aclk) begin : event_check
        event_t got;
        event_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[59:0];
            if (pending_events.size() == 0) begin
                $error("unexpected event item: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (got.stamp !== want.stamp) begin
                    $error("event_time: expected %0h, got %0h", want.stamp, got.stamp);
                    mismatch_count++;
                end
                if (got.level !== want.level) begin
                    $error("event_level: expected %0d, got %0d", want.level, got.level);
                    mismatch_count++;
                end
                if (got.channel !== want.channel) begin
                    $error("event_channel: expected %0d, got %0d", want.channel, got.channel);
                    mismatch_count++;
                end
                if (got.word !== want.word) begin
                    $error("event_word: expected %h, got %h", want.word, got.word);
                    mismatch_count++;
                end
                if (m_axis_tdata[63:60] !== 4'b0000) begin
                    $error("tdata pad: expected 0, got %h", m_axis_tdata[63:60]);
                    mismatch_count++;
                end
            end
        end
    end

    // register values straight out of reset
    task automatic test_register_reset();
        cfg_check(REG_THRESHOLD);
        cfg_check(REG_CHAN_COUNT);
    endtask

    // first sample of every channel counts as a change
    task automatic test_first_scan();
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd40960, 1'b1);
        send_sample(16'd40961, 1'b1);
        send_sample(16'd40959, 1'b1);
        send_sample(16'h5555, 1'b1);
        send_sample(16'hAAAA, 1'b1);
        send_sample(16'h8000, 1'b1);
    endtask

    // threshold at both ends, channel count of zero acts as one
    task automatic test_threshold_extremes();
        cfg_write(REG_CHAN_COUNT, 16'd0);
        cfg_write(REG_THRESHOLD, 16'd0);
        cfg_check(REG_CHAN_COUNT);
        cfg_check(REG_THRESHOLD);
        send_sample(16'd0, 1'b1);
        send_sample(16'd1, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        cfg_write(REG_THRESHOLD, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd0, 1'b1);
    endtask

    // levels move with recording off and make no event; a recorded change then does
    task automatic test_record_off();
        cfg_write(REG_CHAN_COUNT, 16'd1);
        cfg_write(REG_THRESHOLD, 16'd1000);
        send_sample(16'd2000, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'd1001, 1'b1);
    endtask

    // count shrunk below the current index, then count above the maximum
    task automatic test_shrunken_scan();
        cfg_write(REG_CHAN_COUNT, 16'd8);
        for (int i = 0; i < 5; i++) send_sample($urandom_range(0, 65535), 1'b1);
        cfg_write(REG_CHAN_COUNT, 16'd2);
        for (int i = 0; i < 4; i++) send_sample($urandom_range(0, 65535), 1'b1);
        cfg_write(REG_CHAN_COUNT, 16'd15);
        for (int i = 0; i < 3; i++) send_sample($urandom_range(0, 65535), 1'b1);
    endtask

    // long sink hold-off while every item after the first makes an event
    task automatic test_output_stall();
        cfg_write(REG_CHAN_COUNT, 16'd1);
        cfg_write(REG_THRESHOLD, 16'h8000);
        src_gaps = 1'b0;
        hold_len = 200;
        hold_seq++;
        for (int i = 0; i < 60; i++) send_sample((i % 2 == 0) ? 16'h0000 : 16'hFFFF, 1'b1);
        src_gaps = 1'b1;
    endtask

    // source pauses until the block has handed over every event
    task automatic test_drain_pause();
        cfg_write(REG_CHAN_COUNT, 16'd3);
        cfg_write(REG_THRESHOLD, $urandom_range(0, 65535));
        for (int i = 0; i < 20; i++) send_sample(pick_code(), 1'b1);
        wait_drained();
        for (int i = 0; i < 20; i++) send_sample(pick_code(), $urandom_range(0, 3) != 0);
    endtask

    // random streams under a series of settings, extremes first
    task automatic test_random_scans();
        logic [SAMPLE_W-1:0] thr;
        logic [SAMPLE_W-1:0] cnt;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin thr = THRESHOLD_RESET; cnt = 16'd8; end
                1: begin thr = 16'd0; cnt = 16'd1; end
                2: begin thr = 16'hFFFF; cnt = 16'd15; end
                3: begin thr = $urandom_range(0, 65535); cnt = 16'd0; end
                default: begin
                    thr = $urandom_range(0, 65535);
                    cnt = $urandom_range(0, 15);
                end
            endcase
            cfg_write(REG_THRESHOLD, thr);
            cfg_write(REG_CHAN_COUNT, cnt);
            src_gaps = (ph != 0);
            snk_gaps = (ph != 0);
            for (int i = 0; i < 150; i++) send_sample(pick_code(), $urandom_range(0, 99) < 85);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        clear_levels();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn  <= 1'b1;
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        @(negedge aclk);

        test_register_reset();
        test_first_scan();
        test_threshold_extremes();
        test_record_off();
        test_shrunken_scan();
        test_output_stall();
        test_drain_pause();
        test_random_scans();

        wait_drained();
        repeat (20) @(negedge aclk);
        if (pending_events.size() != 0) begin
            $error("%0d expected events never arrived", pending_events.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
